### rtl/core/a128cfb_pkg.sv
// ----------------------------------------------------------------------------
// a128cfb_pkg
// Shared types, constants and AES helper functions for the CFB cipher core.
// ----------------------------------------------------------------------------
package a128cfb_pkg;

    localparam int BlockWidth = 128;

    // register indexes
    localparam logic [2:0] RegKeyHigh  = 3'd0;
    localparam logic [2:0] RegKeyLow   = 3'd1;
    localparam logic [2:0] RegIvHigh   = 3'd2;
    localparam logic [2:0] RegIvLow    = 3'd3;
    localparam logic [2:0] RegDir      = 3'd4;

    typedef logic [BlockWidth-1:0] block_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // next round constant
    function automatic logic [7:0] rcon_next(input logic [7:0] a);
        return xtime(a);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[BlockWidth-1-8*i -: 8];
    endfunction

    // one AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
    function automatic block_t aes_round(input block_t s, input block_t k,
                                         input logic mix);
        logic [7:0] a [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        block_t o;
        for (int i = 0; i < 16; i++)
            a[i] = sbox(get_byte(s, i));
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[c*4+i] = a[((c+i)%4)*4+i];
        if (mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[BlockWidth-1-8*i -: 8] = t[i];
        return o ^ k;
    endfunction

    // one key schedule step
    function automatic block_t key_step(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        t = t ^ {rc, 24'h0};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### rtl/core/aes128_cfb_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_cfb_cipher_core
// AES-128 full-block CFB cipher with PKCS#7 pad insertion and checking.
// ----------------------------------------------------------------------------
// Each block is loaded, runs 10 rounds through the single round unit and is
// held as the result until the output takes it; a new transfer is taken only
// once the core is idle again. An encrypt full last block runs two passes.
// A key write starts a key expansion into the round key memory.
// Reset: asynchronous active low; clears the control and data registers (not
// the result and output registers) and expands the zero key before the first
// block or register write is taken.
module aes128_cfb_cipher_core
(
    input  logic         clk,
    input  logic         rst_n,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // block_high, block_low, byte_count, zero fill
    input  logic         s_tlast,  // last_block
    input  logic         s_tuser,  // restart
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // data_high, data_low, valid_bytes, zero fill
    output logic         m_tlast,  // last_out
    output logic         m_tuser   // pad_error
);

    localparam logic [2:0] StKey  = 3'd0;
    localparam logic [2:0] StIdle = 3'd1;
    localparam logic [2:0] StRnd  = 3'd2;
    localparam logic [2:0] StOut  = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg;
    logic [7:0]  rc_reg;
    a128cfb_pkg::block_t rk_mem [11];
    a128cfb_pkg::block_t kexp_reg;
    a128cfb_pkg::block_t rk_rd_reg;
    a128cfb_pkg::block_t st_reg, fb_reg, blk_reg, res_reg;
    logic [63:0] key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg;
    logic        dir_reg;
    logic        last_reg, extra_reg, olast_reg, oerr_reg;
    logic [4:0]  ovb_reg;

    a128cfb_pkg::block_t blk_in, ks, res_c;
    logic [4:0]  cnt_in;
    logic [7:0]  pbyte;

    assign cfg_ready = (state_reg == StIdle);
    assign s_tready  = (state_reg == StIdle) && !cfg_valid;
    assign m_tvalid  = (state_reg == StOut);
    assign m_tdata   = {3'b000, ovb_reg, res_reg[63:0], res_reg[127:64]};
    assign m_tlast   = olast_reg;
    assign m_tuser   = oerr_reg;

    // input block, with the PKCS#7 pad applied to an encrypt last block
    always_comb
    begin
        cnt_in = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
        blk_in = {s_tdata[63:0], s_tdata[127:64]};
        if (!dir_reg && s_tlast)
        begin
            for (int i = 0; i < 16; i++)
                if (5'(i) >= cnt_in)
                    blk_in[127-8*i -: 8] = 8'(5'd16 - cnt_in);
        end
    end

    // shared round unit; the last round skips MixColumns
    assign ks    = a128cfb_pkg::aes_round(st_reg, rk_rd_reg, cnt_reg != 4'd10);
    assign res_c = ks ^ blk_reg;
    assign pbyte = res_c[7:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            StKey:  if (cnt_reg == 4'd10) state_next = StIdle;
            StIdle:
            begin
                if (cfg_valid && (cfg_index == a128cfb_pkg::RegKeyHigh ||
                                  cfg_index == a128cfb_pkg::RegKeyLow))
                    state_next = StKey;
                else if (s_tvalid && s_tready)
                    state_next = StRnd;
            end
            StRnd:  if (cnt_reg == 4'd10) state_next = StOut;
            StOut:  if (m_tready) state_next = extra_reg ? StRnd : StIdle;
            default: state_next = StIdle;
        endcase
    end

    // round key memory: one write per expansion step, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == StKey)
            rk_mem[cnt_reg] <= kexp_reg;
        rk_rd_reg <= rk_mem[(state_next == StRnd) ?
                            ((state_reg == StRnd) ? cnt_reg + 4'd1 : 4'd0) : 4'd0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= StKey;
            cnt_reg    <= 4'd0;
            rc_reg     <= 8'h01;
            kexp_reg   <= '0;
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            iv_hi_reg  <= '0;
            iv_lo_reg  <= '0;
            dir_reg    <= 1'b0;
            fb_reg     <= '0;
            blk_reg    <= '0;
            st_reg     <= '0;
            last_reg   <= 1'b0;
            extra_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // config writes, taken only while idle
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    a128cfb_pkg::RegKeyHigh:
                    begin
                        key_hi_reg <= cfg_data;
                        kexp_reg   <= {cfg_data, key_lo_reg};
                    end
                    a128cfb_pkg::RegKeyLow:
                    begin
                        key_lo_reg <= cfg_data;
                        kexp_reg   <= {key_hi_reg, cfg_data};
                    end
                    a128cfb_pkg::RegIvHigh: iv_hi_reg <= cfg_data;
                    a128cfb_pkg::RegIvLow:  iv_lo_reg <= cfg_data;
                    a128cfb_pkg::RegDir:    dir_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                StKey:
                begin
                    if (cnt_reg == 4'd10)
                    begin
                        cnt_reg <= 4'd0;
                        rc_reg  <= 8'h01;
                    end
                    else
                    begin
                        cnt_reg  <= cnt_reg + 4'd1;
                        rc_reg   <= a128cfb_pkg::rcon_next(rc_reg);
                        kexp_reg <= a128cfb_pkg::key_step(kexp_reg, rc_reg);
                    end
                end
                StIdle:
                begin
                    cnt_reg <= 4'd0;
                    rc_reg  <= 8'h01;
                    if (s_tvalid && s_tready)
                    begin
                        blk_reg   <= blk_in;
                        last_reg  <= s_tlast;
                        extra_reg <= !dir_reg && s_tlast && (cnt_in == 5'd16);
                        if (s_tuser)
                            fb_reg <= {iv_hi_reg, iv_lo_reg};
                    end
                end
                StRnd:
                begin
                    if (cnt_reg == 4'd0)
                        st_reg <= fb_reg ^ rk_rd_reg;
                    else
                        st_reg <= ks;
                    if (cnt_reg == 4'd10)
                    begin
                        cnt_reg <= 4'd0;
                        // ciphertext feeds back in both directions
                        fb_reg  <= dir_reg ? blk_reg : res_c;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                StOut:
                begin
                    if (m_tready && extra_reg)
                    begin
                        extra_reg <= 1'b0;
                        blk_reg   <= {16{8'h10}};
                    end
                end
                default: ;
            endcase
        end
    end

    // result register and pad check, loaded as the last round completes
    always_ff @(posedge clk)
    begin
        if (state_reg == StRnd && cnt_reg == 4'd10)
        begin
            res_reg   <= res_c;
            olast_reg <= last_reg && !extra_reg;
            if (dir_reg && last_reg && (pbyte == 8'd0 || pbyte > 8'd16))
            begin
                oerr_reg <= 1'b1;
                ovb_reg  <= 5'd16;
            end
            else if (dir_reg && last_reg)
            begin
                oerr_reg <= 1'b0;
                ovb_reg  <= 5'd16 - pbyte[4:0];
            end
            else
            begin
                oerr_reg <= 1'b0;
                ovb_reg  <= 5'd16;
            end
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StRnd) |-> !s_tready)
        else $error("input taken during rounds");
    a_cfg_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StRnd) |-> !cfg_ready)
        else $error("config accepted during rounds");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= 4'd10))
        else $error("round counter overrun");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while stalled");
`endif

endmodule

### dv/cfb_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfb_result_checker
// Watches the config, input and output channels of the AES-128 CFB core,
// keeps its own copy of key, IV, direction and feedback, predicts every
// result block and compares each output transfer against the oldest one.
// ----------------------------------------------------------------------------
module cfb_result_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,   // block_high, block_low, byte_count, zero fill
    input  logic         s_tlast,   // last_block
    input  logic         s_tuser,   // restart
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,   // data_high, data_low, valid_bytes, zero fill
    input  logic         m_tlast,   // last_out
    input  logic         m_tuser,   // pad_error
    output int           mismatches,
    output int           pending,
    output int           checked
);

    typedef struct packed {
        logic [127:0] data;
        logic [4:0]   nbytes;
        logic         last;
        logic         err;
    } cfb_result_t;

    cfb_result_t  expected_blocks[$];
    logic [7:0]   sub_tab[256];
    logic [127:0] rkey[11];
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         decrypt;
    logic [127:0] chain;
    int           miss_cnt;
    int           check_cnt;

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // S-box built from the field inverse and the affine map
    initial
    begin
        logic [7:0] inv, t, s;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(a[7:0], b[7:0]) == 8'h01)
                    inv = b[7:0];
            t = inv;
            s = inv;
            repeat (4)
            begin
                t = {t[6:0], t[7]};
                s = s ^ t;
            end
            sub_tab[a] = s ^ 8'h63;
        end
    end

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    // key schedule into rkey[0..10]
    function automatic void expand_keys(input logic [127:0] k);
        logic [31:0] w0, w1, w2, w3, t;
        logic [7:0]  rc;
        rkey[0] = k;
        rc = 8'h01;
        for (int r = 1; r <= 10; r++)
        begin
            {w0, w1, w2, w3} = rkey[r-1];
            t = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            rkey[r] = {w0, w1, w2, w3};
            rc = gf_dbl(rc);
        end
    endfunction

    function automatic logic [127:0] cipher(input logic [127:0] x);
        logic [7:0]   b[16];
        logic [7:0]   t[16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] s;
        s = x ^ rkey[0];
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                b[i] = sub_tab[s[127-8*i -: 8]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[c*4+i] = b[((c+i)%4)*4+i];
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[127-8*i -: 8] = t[i];
            s = s ^ rkey[r];
        end
        return s;
    endfunction

    function automatic void push_result(input logic [127:0] d, input logic [4:0] n,
                                        input logic l, input logic e);
        cfb_result_t r;
        r.data   = d;
        r.nbytes = n;
        r.last   = l;
        r.err    = e;
        expected_blocks.push_back(r);
    endfunction

    // encrypt one block: ciphertext feeds back
    function automatic void encrypt_push(input logic [127:0] blk, input logic l);
        logic [127:0] res;
        res = cipher(chain) ^ blk;
        chain = res;
        push_result(res, 5'd16, l, 1'b0);
    endfunction

    function automatic void predict_block();
        logic [127:0] blk, res;
        logic [4:0]   cnt;
        logic [7:0]   p;
        blk = {s_tdata[63:0], s_tdata[127:64]};
        cnt = s_tdata[132:128];
        if (s_tuser)
            chain = {iv_hi, iv_lo};
        if (!decrypt)
        begin
            if (cnt > 5'd16)
                cnt = 5'd16;
            if (!s_tlast)
                encrypt_push(blk, 1'b0);
            else if (cnt < 5'd16)
            begin
                // PKCS#7 fill of the tail bytes
                for (int i = 0; i < 16; i++)
                    if (i >= cnt)
                        blk[127-8*i -: 8] = 8'd16 - {3'b0, cnt};
                encrypt_push(blk, 1'b1);
            end
            else
            begin
                // full last block: extra all-pad block follows
                encrypt_push(blk, 1'b0);
                encrypt_push({16{8'h10}}, 1'b1);
            end
        end
        else
        begin
            res = cipher(chain) ^ blk;
            chain = blk;
            p = res[7:0];
            if (!s_tlast)
                push_result(res, 5'd16, 1'b0, 1'b0);
            else if (p == 8'd0 || p > 8'd16)
                push_result(res, 5'd16, 1'b1, 1'b1);
            else
                push_result(res, 5'd16 - p[4:0], 1'b1, 1'b0);
        end
    endfunction

    // compare one output transfer with the oldest expectation
    function automatic void check_result();
        cfb_result_t want, got;
        got.data   = {m_tdata[63:0], m_tdata[127:64]};
        got.nbytes = m_tdata[132:128];
        got.last   = m_tlast;
        got.err    = m_tuser;
        if (expected_blocks.size() == 0)
        begin
            miss_cnt++;
            if (miss_cnt <= 10)
                $display("%0t: unexpected result data=%h bytes=%0d last=%b err=%b",
                         $realtime, got.data, got.nbytes, got.last, got.err);
            return;
        end
        want = expected_blocks.pop_front();
        check_cnt++;
        if (got !== want)
        begin
            miss_cnt++;
            if (miss_cnt <= 10)
            begin
                $display("%0t: result mismatch", $realtime);
                $display("  exp data=%h bytes=%0d last=%b err=%b",
                         want.data, want.nbytes, want.last, want.err);
                $display("  got data=%h bytes=%0d last=%b err=%b",
                         got.data, got.nbytes, got.last, got.err);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi = '0;
            key_lo = '0;
            iv_hi = '0;
            iv_lo = '0;
            decrypt = 1'b0;
            chain = '0;
            miss_cnt = 0;
            check_cnt = 0;
            expected_blocks.delete();
            expand_keys('0);
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    a128cfb_pkg::RegKeyHigh:
                    begin
                        key_hi = cfg_data;
                        expand_keys({key_hi, key_lo});
                    end
                    a128cfb_pkg::RegKeyLow:
                    begin
                        key_lo = cfg_data;
                        expand_keys({key_hi, key_lo});
                    end
                    a128cfb_pkg::RegIvHigh: iv_hi = cfg_data;
                    a128cfb_pkg::RegIvLow:  iv_lo = cfg_data;
                    a128cfb_pkg::RegDir:    decrypt = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                predict_block();
        end
        mismatches <= miss_cnt;
        checked <= check_cnt;
        pending <= expected_blocks.size();
    end

endmodule

### dv/tb_aes128_cfb_cipher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes128_cfb_cipher_core
// Stimulus for the AES-128 CFB core: directed padding corners, then phases
// that encrypt random messages, replay the captured ciphertext in decrypt
// mode (some with a damaged pad) and add random noise blocks.
// ----------------------------------------------------------------------------
module tb_aes128_cfb_cipher_core;

    localparam logic [2:0] RegUnused = 3'd7;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } cipher_blk_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    int           mismatches;
    int           pending;
    int           checked;
    int           items_sent;
    int           burst_left;
    int           phases;
    int           rx_cycle;
    bit           capture;
    cipher_blk_t  captured[$];

    always #2 clk = ~clk;

    aes128_cfb_cipher_core dut (.*);

    cfb_result_checker checker_i (.*);

    // receiver stall pattern: always ready, mostly ready, periodic, rarely ready
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 320) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((rx_cycle % 9) < 4);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // capture ciphertext while encrypting, for the decrypt replay
    always @(posedge clk)
    begin
        cipher_blk_t c;
        if (capture && m_tvalid && m_tready)
        begin
            c.hi = m_tdata[63:0];
            c.lo = m_tdata[127:64];
            c.last = m_tlast;
            captured.push_back(c);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] cnt, input logic last, input logic rs);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, cnt, lo, hi};
        s_tlast <= last;
        s_tuser <= rs;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    // stop the sender and let every expected result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [4:0]  cnt;
        int          len;
        bit          start;
        cipher_blk_t c;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: zero key and IV, padding corners
        write_reg(a128cfb_pkg::RegKeyHigh, '0);
        write_reg(a128cfb_pkg::RegKeyLow, '0);
        write_reg(a128cfb_pkg::RegIvHigh, '0);
        write_reg(a128cfb_pkg::RegIvLow, '0);
        write_reg(a128cfb_pkg::RegDir, 64'd0);
        capture = 1'b1;
        send_block('0, '0, 5'd16, 1'b0, 1'b1);
        send_block('1, '1, 5'd3, 1'b0, 1'b0);
        send_block('1, '0, 5'd0, 1'b1, 1'b0);
        send_block(rnd64(), rnd64(), 5'd1, 1'b1, 1'b1);
        send_block(rnd64(), rnd64(), 5'd15, 1'b1, 1'b1);
        send_block('0, '1, 5'd16, 1'b1, 1'b1);
        send_block(rnd64(), rnd64(), 5'd17, 1'b1, 1'b1);
        send_block('1, '1, 5'd31, 1'b1, 1'b1);
        send_block(rnd64(), rnd64(), 5'd8, 1'b0, 1'b1);
        send_block(rnd64(), rnd64(), 5'd8, 1'b0, 1'b1);   // restart mid message
        send_block(rnd64(), rnd64(), 5'd8, 1'b1, 1'b0);
        wait_idle();
        capture = 1'b0;
        captured.delete();

        // directed decrypt: random tails give mostly bad pads
        write_reg(a128cfb_pkg::RegDir, 64'd1);
        send_block('0, '0, 5'd0, 1'b1, 1'b1);
        send_block('1, '1, 5'd31, 1'b1, 1'b1);
        send_block(rnd64(), rnd64(), 5'd16, 1'b0, 1'b1);
        send_block(rnd64(), rnd64(), 5'd16, 1'b1, 1'b0);
        wait_idle();
        write_reg(a128cfb_pkg::RegDir, 64'd0);

        // random phases: encrypt, replay as decrypt, noise
        phases = 0;
        while (items_sent < 1650)
        begin
            case (phases)
                0:
                begin
                    write_reg(a128cfb_pkg::RegKeyHigh, '1);
                    write_reg(a128cfb_pkg::RegKeyLow, '1);
                    write_reg(a128cfb_pkg::RegIvHigh, '1);
                    write_reg(a128cfb_pkg::RegIvLow, '1);
                end
                1:
                begin
                    write_reg(a128cfb_pkg::RegKeyHigh, '0);
                    write_reg(a128cfb_pkg::RegKeyLow, '1);
                    write_reg(a128cfb_pkg::RegIvHigh, '0);
                    write_reg(a128cfb_pkg::RegIvLow, '1);
                end
                default:
                begin
                    write_reg(a128cfb_pkg::RegKeyHigh, rnd64());
                    write_reg(a128cfb_pkg::RegKeyLow, rnd64());
                    write_reg(a128cfb_pkg::RegIvHigh, rnd64());
                    write_reg(a128cfb_pkg::RegIvLow, rnd64());
                end
            endcase
            if (phases % 3 == 0)
                write_reg(RegUnused - phases[0], rnd64());   // out-of-range index

            // encrypt messages and keep their ciphertext
            capture = 1'b1;
            repeat ($urandom_range(3, 8))
            begin
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++)
                begin
                    cnt = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                      : 5'($urandom_range(0, 16));
                    send_block(rnd64(), rnd64(), cnt, j == len - 1, j == 0);
                end
            end
            wait_idle();
            capture = 1'b0;

            // replay as decrypt; some pads damaged
            write_reg(a128cfb_pkg::RegDir, 64'd1);
            start = 1'b1;
            while (captured.size() != 0)
            begin
                c = captured.pop_front();
                if (c.last && $urandom_range(0, 5) == 0)
                    c.lo[7:0] = c.lo[7:0] ^ 8'($urandom_range(1, 255));
                send_block(c.hi, c.lo, 5'($urandom_range(0, 31)), c.last, start);
                start = c.last;
            end
            repeat ($urandom_range(2, 6))
                send_block(rnd64(), rnd64(), 5'($urandom_range(0, 31)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            wait_idle();
            write_reg(a128cfb_pkg::RegDir, 64'd0);
            phases++;
        end

        wait_idle();
        $display("tb: %0d blocks sent over %0d key/IV phases, %0d results checked",
                 items_sent, phases, checked);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
